### hdl/sdpc_pkg.sv
// Package for the switch debounce and press counter block.
// Holds shared types, command codes, register indexes and widths.
// No dependencies.
`timescale 1ns / 1ps

package sdpc_pkg;

	// Default width of the press window timer
	localparam int TIMER_BITS_DEF = 16;

	// Configuration port
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MOMENTARY_MODE    = 2'd0,
		REG_DEBOUNCE_TOP      = 2'd1,
		REG_RESET_PRESS_LIMIT = 2'd2,
		REG_WINDOW_TICKS      = 2'd3
	} reg_idx_t;

	// Commands from pin handling
	typedef enum logic [1:0] {
		CMD_NONE   = 2'd0,
		CMD_ON     = 2'd1,
		CMD_OFF    = 2'd2,
		CMD_TOGGLE = 2'd3
	} cmd_t;

	// Debounce and press count limits
	localparam logic [3:0] DEBOUNCE_MIN   = 4'd2;
	localparam logic [3:0] DEBOUNCE_IDLE  = 4'd1;
	localparam logic [7:0] PRESS_COUNT_MAX = 8'd255;

	// Register reset values
	localparam logic [3:0]  DEBOUNCE_TOP_RST = 4'd8;
	localparam logic [7:0]  PRESS_LIMIT_RST  = 8'd8;
	localparam logic [15:0] WINDOW_TICKS_RST = 16'd100;

	typedef struct packed {
		logic        momentary_mode;
		logic [3:0]  debounce_top;
		logic [7:0]  reset_press_limit;
		logic [15:0] window_ticks;
	} cfg_t;

	typedef struct packed {
		logic busy_res;
		logic pressed;
		logic reset_req;
		logic window_off;
		cmd_t pin_command;
	} res_t;

endpackage

### hdl/sdpc_cfg.sv
// Configuration registers of the switch debounce block.
// Depends on sdpc_pkg.
`timescale 1ns / 1ps

module sdpc_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sdpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sdpc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output sdpc_pkg::cfg_t                    cfg
);
	import sdpc_pkg::*;

	cfg_t cfg_q;

	// Register writes, one index per write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.momentary_mode    <= 1'b0;
			cfg_q.debounce_top      <= DEBOUNCE_TOP_RST;
			cfg_q.reset_press_limit <= PRESS_LIMIT_RST;
			cfg_q.window_ticks      <= WINDOW_TICKS_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MOMENTARY_MODE:    cfg_q.momentary_mode    <= cfg_data[0];
				REG_DEBOUNCE_TOP:      cfg_q.debounce_top      <= cfg_data[3:0];
				REG_RESET_PRESS_LIMIT: cfg_q.reset_press_limit <= cfg_data[7:0];
				REG_WINDOW_TICKS:      cfg_q.window_ticks      <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hdl/sdpc_core.sv
// Debounce counter, press counter and press window timer.
// Depends on sdpc_pkg.
`timescale 1ns / 1ps

module sdpc_core #(
	parameter int TIMER_BITS = sdpc_pkg::TIMER_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           pin_level,
	input  sdpc_pkg::cfg_t cfg,
	output sdpc_pkg::res_t res
);
	import sdpc_pkg::*;

	logic                  is_pressed_q;
	logic [3:0]            debounce_count_q;
	logic [7:0]            press_count_q;
	logic                  window_open_q;
	logic [TIMER_BITS-1:0] window_remaining_q;

	logic                  is_pressed_n;
	logic [3:0]            debounce_count_n;
	logic [7:0]            press_count_n;
	logic                  window_open_n;
	logic [TIMER_BITS-1:0] window_remaining_n;

	logic [3:0]            top;
	logic [3:0]            cnt_up;
	logic [TIMER_BITS-1:0] load;
	logic                  expire;
	logic [7:0]            pc_exp;
	logic                  wo_exp;
	cmd_t                  cmd;

	assign top    = (cfg.debounce_top < DEBOUNCE_MIN) ? DEBOUNCE_MIN : cfg.debounce_top;
	assign cnt_up = (debounce_count_q < top) ? debounce_count_q + 4'd1 : debounce_count_q;
	assign load   = TIMER_BITS'(cfg.window_ticks);
	assign expire = window_open_q && (window_remaining_q <= TIMER_BITS'(1));
	assign pc_exp = expire ? 8'd0 : press_count_q;
	assign wo_exp = expire ? 1'b0 : window_open_q;

	// Window expiry first, then pin handling
	always_comb begin
		is_pressed_n       = is_pressed_q;
		debounce_count_n   = debounce_count_q;
		press_count_n      = pc_exp;
		window_open_n      = wo_exp;
		window_remaining_n = window_remaining_q;
		cmd                = CMD_NONE;

		if (window_open_q) begin
			window_remaining_n = expire ? '0 : window_remaining_q - TIMER_BITS'(1);
		end

		if (pin_level) begin
			if (!is_pressed_q) begin
				debounce_count_n = cnt_up;
				if (cnt_up >= top) begin
					debounce_count_n   = top;
					is_pressed_n       = 1'b1;
					press_count_n      = (pc_exp < PRESS_COUNT_MAX) ? pc_exp + 8'd1 : pc_exp;
					window_open_n      = 1'b1;
					window_remaining_n = (load == '0) ? TIMER_BITS'(1) : load;
					if (pc_exp == 8'd0) begin
						cmd = cfg.momentary_mode ? CMD_ON : CMD_TOGGLE;
					end
				end
			end
		end else if (is_pressed_q && debounce_count_q > DEBOUNCE_IDLE) begin
			debounce_count_n = debounce_count_q - 4'd1;
			if (debounce_count_n == DEBOUNCE_IDLE) begin
				is_pressed_n = 1'b0;
				if (!wo_exp && cfg.momentary_mode) begin
					cmd = CMD_OFF;
				end
			end
		end
	end

	// Result of the tick
	always_comb begin
		res.pin_command = cmd;
		res.window_off  = expire && cfg.momentary_mode && !is_pressed_q;
		res.reset_req   = expire && (press_count_q >= cfg.reset_press_limit);
		res.pressed     = is_pressed_n;
		res.busy_res    = (debounce_count_n != DEBOUNCE_IDLE && debounce_count_n != top)
			|| window_open_n;
	end

	// State update once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_pressed_q       <= 1'b0;
			debounce_count_q   <= DEBOUNCE_IDLE;
			press_count_q      <= 8'd0;
			window_open_q      <= 1'b0;
			window_remaining_q <= '0;
		end else if (adv) begin
			is_pressed_q       <= is_pressed_n;
			debounce_count_q   <= debounce_count_n;
			press_count_q      <= press_count_n;
			window_open_q      <= window_open_n;
			window_remaining_q <= window_remaining_n;
		end
	end

endmodule

### hdl/sdpc_outreg.sv
// Result register on the master side of the switch debounce block.
// Depends on sdpc_pkg.
`timescale 1ns / 1ps

module sdpc_outreg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  sdpc_pkg::res_t res,
	output logic           free,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [7:0]     m_tdata
);
	import sdpc_pkg::*;

	logic valid_q;
	res_t res_q;

	assign free = !valid_q || m_tready;

	// Valid flag: set on load, cleared once the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {2'b00, res_q};

endmodule

### hdl/switch_debounce_press_counter.sv
// Top level of the switch debounce and multi-press counter.
// Depends on sdpc_pkg, sdpc_cfg, sdpc_core and sdpc_outreg.
//
//   channel  | direction | payload
//   s_*      | in        | one poll tick: s_tdata[0] pin_level
//   m_*      | out       | one result per tick, fields in m_tdata
//   cfg_*    | in        | register write, index 0..3, 16-bit data
//
// One tick is accepted every cycle while s_tready is high; each tick passes the
// input register, then the result register. The state counters update in
// the cycle a tick moves from the input register into the result register.
// Reset sets the registers to their defaults and the switch to released.
// A stalled m_tready holds the result register and then the input register;
// s_tready drops only when both are full.
`timescale 1ns / 1ps

module switch_debounce_press_counter #(
	parameter int TIMER_BITS = sdpc_pkg::TIMER_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [0] pin_level
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [1:0] pin_command, [2] window_off, [3] reset_req, [4] pressed, [5] busy_res
	output logic [7:0]                      m_tdata,
	input  logic                            cfg_we,
	input  logic [sdpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sdpc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sdpc_pkg::*;

	cfg_t cfg;
	res_t res;
	logic valid_s1;
	logic pin_s1;
	logic out_free;
	logic adv;
	logic in_fire;

	assign adv      = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign in_fire  = s_tvalid && s_tready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pin_s1 <= s_tdata[0];
		end
	end

	sdpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sdpc_core #(
		.TIMER_BITS (TIMER_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.pin_level (pin_s1),
		.cfg       (cfg),
		.res       (res)
	);

	sdpc_outreg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv),
		.res      (res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

`ifndef SYNTHESIS
	// Both stages full and stalled: no new tick may enter
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && m_tvalid && !m_tready) |-> !s_tready)
		else $error("tick accepted while pipeline full");

	// On or toggle only when the switch has just become pressed
	a_on_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[1:0] == CMD_ON || m_tdata[1:0] == CMD_TOGGLE)) |-> m_tdata[4])
		else $error("on or toggle with switch released");

	// Off from pin handling only with the switch released
	a_off_released: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1:0] == CMD_OFF) |-> !m_tdata[4])
		else $error("off command with switch pressed");
`endif

endmodule

### test/tb_switch_debounce_press_counter.sv
// Testbench for switch_debounce_press_counter: a directed plan, then press-shaped random ticks.
// Each result is checked against a typed plan row or the in-bench debounce and window model.
// Depends on sdpc_pkg and the block itself.
`timescale 1ns / 1ps

module tb_switch_debounce_press_counter;
	import sdpc_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 60;
	localparam int PLAN_LEN    = 35;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [0] pin_level
	logic        m_tvalid;
	logic        m_tready;
	// [1:0] pin_command, [2] window_off, [3] reset_req, [4] pressed, [5] busy_res
	logic [7:0]  m_tdata;
	logic        cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	switch_debounce_press_counter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Model copy of the registers
	logic        mode_mom  = 1'b0;
	logic [3:0]  db_top    = DEBOUNCE_TOP_RST;
	logic [7:0]  press_lim = PRESS_LIMIT_RST;
	logic [15:0] win_len   = WINDOW_TICKS_RST;

	// Model copy of the switch state
	logic        sw_down  = 1'b0;
	logic [3:0]  db_cnt   = DEBOUNCE_IDLE;
	logic [7:0]  presses  = '0;
	logic        win_open = 1'b0;
	logic [15:0] win_left = '0;

	res_t pending_res [$];
	int   fails      = 0;
	int   ticks_sent = 0;
	int   results    = 0;
	int   writes     = 0;
	int   cmd_seen [4] = '{0, 0, 0, 0};
	int   woff_seen  = 0;
	int   freset_seen = 0;
	int   burst_left = 0;
	bit   gapless    = 1'b0;
	bit   hold_req   = 1'b0;

	// Directed plan
	typedef enum bit {ROW_TICK, ROW_WRITE} row_kind_t;
	typedef struct {
		row_kind_t   kind;
		reg_idx_t    idx;
		logic [15:0] val;   // pin in bit 0 for a tick
		bit          typed;
		res_t        want;
	} plan_row_t;

	localparam res_t NO_RES     = '0;
	localparam res_t IDLE_LOW   = '{1'b0, 1'b0, 1'b0, 1'b0, CMD_NONE};
	localparam res_t FIRST_RISE = '{1'b1, 1'b0, 1'b0, 1'b0, CMD_NONE};
	localparam res_t FIRST_TGL  = '{1'b1, 1'b1, 1'b0, 1'b0, CMD_TOGGLE};

	plan_row_t plan_tab [PLAN_LEN] = '{
		'{ROW_TICK,  REG_MOMENTARY_MODE,    16'd0,     1'b1, IDLE_LOW},
		'{ROW_TICK,  REG_MOMENTARY_MODE,    16'd1,     1'b1, FIRST_RISE},
		// top below two acts as two, so the count already there presses
		'{ROW_WRITE, REG_DEBOUNCE_TOP,      16'd0,     1'b0, NO_RES},
		'{ROW_TICK,  REG_MOMENTARY_MODE,    16'd1,     1'b1, FIRST_TGL},
		'{ROW_WRITE, REG_MOMENTARY_MODE,    16'd1,     1'b0, NO_RES},
		'{ROW_WRITE, REG_WINDOW_TICKS,      16'd0,     1'b0, NO_RES},
		'{ROW_TICK,  REG_MOMENTARY_MODE,    16'd0,     1'b0, NO_RES},
		'{ROW_TICK,  REG_MOMENTARY_MODE,    16'd1,     1'b0, NO_RES},
		'{ROW_TICK,  REG_MOMENTARY_MODE,    16'd1,     1'b0, NO_RES},
		'{ROW_TICK,  REG_MOMENTARY_MODE,    16'd0,     1'b0, NO_RES},
		// zero limit: every expiry requests factory reset
		'{ROW_WRITE, REG_RESET_PRESS_LIMIT, 16'd0,     1'b0, NO_RES},
		'{ROW_TICK,  REG_MOMENTARY_MODE,    16'd1,     1'b0, NO_RES},
		'{ROW_TICK,  REG_MOMENTARY_MODE,    16'd0,     1'b0, NO_RES},
		'{ROW_TICK,  REG_MOMENTARY_MODE,    16'd1,     1'b0, NO_RES},
		'{ROW_TICK,  REG_MOMENTARY_MODE,    16'd1,     1'b0, NO_RES},
		'{ROW_TICK,  REG_MOMENTARY_MODE,    16'd0,     1'b0, NO_RES},
		// expiry while released gives the window off
		'{ROW_WRITE, REG_WINDOW_TICKS,      16'd2,     1'b0, NO_RES},
		'{ROW_TICK,  REG_MOMENTARY_MODE,    16'd1,     1'b0, NO_RES},
		'{ROW_TICK,  REG_MOMENTARY_MODE,    16'd0,     1'b0, NO_RES},
		'{ROW_TICK,  REG_MOMENTARY_MODE,    16'd0,     1'b0, NO_RES},
		// partial count left above a lowered top
		'{ROW_WRITE, REG_DEBOUNCE_TOP,      16'd15,    1'b0, NO_RES},
		'{ROW_WRITE, REG_RESET_PRESS_LIMIT, 16'd1,     1'b0, NO_RES},
		'{ROW_TICK,  REG_MOMENTARY_MODE,    16'd1,     1'b0, NO_RES},
		'{ROW_TICK,  REG_MOMENTARY_MODE,    16'd1,     1'b0, NO_RES},
		'{ROW_TICK,  REG_MOMENTARY_MODE,    16'd1,     1'b0, NO_RES},
		'{ROW_WRITE, REG_DEBOUNCE_TOP,      16'd3,     1'b0, NO_RES},
		'{ROW_TICK,  REG_MOMENTARY_MODE,    16'd1,     1'b0, NO_RES},
		'{ROW_TICK,  REG_MOMENTARY_MODE,    16'd0,     1'b0, NO_RES},
		// expiry and release in the same tick
		'{ROW_TICK,  REG_MOMENTARY_MODE,    16'd0,     1'b0, NO_RES},
		'{ROW_WRITE, REG_DEBOUNCE_TOP,      16'd1,     1'b0, NO_RES},
		'{ROW_WRITE, REG_WINDOW_TICKS,      16'd65535, 1'b0, NO_RES},
		'{ROW_WRITE, REG_RESET_PRESS_LIMIT, 16'd255,   1'b0, NO_RES},
		'{ROW_WRITE, REG_MOMENTARY_MODE,    16'd0,     1'b0, NO_RES},
		'{ROW_TICK,  REG_MOMENTARY_MODE,    16'd1,     1'b0, NO_RES},
		'{ROW_TICK,  REG_MOMENTARY_MODE,    16'd0,     1'b0, NO_RES}
	};

	// One poll tick of the debounce and press window; updates the model state
	function automatic res_t debounce_tick(input logic pin);
		logic [3:0] top;
		res_t       r;
		top = (db_top < DEBOUNCE_MIN) ? DEBOUNCE_MIN : db_top;
		r = '0;
		// window expiry comes first
		if (win_open) begin
			if (win_left <= 16'd1) begin
				win_left = '0;
				if (presses >= press_lim)
					r.reset_req = 1'b1;
				if (mode_mom && !sw_down)
					r.window_off = 1'b1;
				presses  = '0;
				win_open = 1'b0;
			end else begin
				win_left = win_left - 16'd1;
			end
		end
		// pin handling
		if (pin) begin
			if (!sw_down) begin
				if (db_cnt < top)
					db_cnt = db_cnt + 4'd1;
				if (db_cnt >= top) begin
					db_cnt   = top;
					sw_down  = 1'b1;
					if (presses != PRESS_COUNT_MAX)
						presses = presses + 8'd1;
					win_open = 1'b1;
					win_left = (win_len == '0) ? 16'd1 : win_len;
					if (presses == 8'd1)
						r.pin_command = mode_mom ? CMD_ON : CMD_TOGGLE;
				end
			end
		end else if (sw_down && db_cnt > DEBOUNCE_IDLE) begin
			db_cnt = db_cnt - 4'd1;
			if (db_cnt == DEBOUNCE_IDLE) begin
				sw_down = 1'b0;
				if (!win_open && mode_mom)
					r.pin_command = CMD_OFF;
			end
		end
		r.pressed  = sw_down;
		r.busy_res = (db_cnt != DEBOUNCE_IDLE && db_cnt != top) || win_open;
		return r;
	endfunction

	// Offer one tick, with a random gap at each burst boundary unless gapless is set
	task automatic send_tick(input logic pin, input bit typed, input res_t want);
		int gap;
		cfg_we <= 1'b0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0 && !gapless) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tdata  <= {7'd0, pin};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		want = typed ? want : debounce_tick(pin);
		if (typed)
			void'(debounce_tick(pin));
		pending_res.push_back(want);
		ticks_sent++;
	endtask

	// Stop sending and wait for every outstanding result
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		cfg_we   <= 1'b0;
		@(posedge clk);
		while (pending_res.size() != 0) @(posedge clk);
	endtask

	// Register write; the enable is lowered by the next tick or wait_drained
	task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_MOMENTARY_MODE:    mode_mom  = val[0];
			REG_DEBOUNCE_TOP:      db_top    = val[3:0];
			REG_RESET_PRESS_LIMIT: press_lim = val[7:0];
			REG_WINDOW_TICKS:      win_len   = val;
			default: ;
		endcase
		writes++;
	endtask

	task automatic set_mode(input logic mom, input logic [3:0] top,
			input logic [7:0] lim, input logic [15:0] win);
		wait_drained();
		write_reg(REG_MOMENTARY_MODE, {15'd0, mom});
		write_reg(REG_DEBOUNCE_TOP, {12'd0, top});
		write_reg(REG_RESET_PRESS_LIMIT, {8'd0, lim});
		write_reg(REG_WINDOW_TICKS, win);
	endtask

	// Mostly press/release shapes around the debounce top, some pin noise
	task automatic press_mix(input int n);
		int stop_at, len, k, top_eff, wcap;
		stop_at = ticks_sent + n;
		while (ticks_sent < stop_at) begin
			top_eff = (db_top < DEBOUNCE_MIN) ? 2 : int'(db_top);
			wcap    = (win_len > 16'd60) ? 62 : int'(win_len) + 2;
			if ($urandom_range(0, 9) < 2) begin
				len = $urandom_range(1, 6);
				for (k = 0; k < len; k++)
					send_tick(1'($urandom_range(0, 1)), 1'b0, NO_RES);
			end else begin
				len = top_eff - 2 + $urandom_range(0, 5);
				for (k = 0; k < len; k++)
					send_tick(1'b1, 1'b0, NO_RES);
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, wcap)
					: $urandom_range(1, top_eff + 2);
				for (k = 0; k < len; k++)
					send_tick(1'b0, 1'b0, NO_RES);
			end
		end
	endtask

	// Receiver pacing: ready runs, random stalls, sparse ready, one long hold-off
	initial begin : rx_pace
		int seg, style, i;
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			style = $urandom_range(0, 2);
			seg   = $urandom_range(1, 40);
			for (i = 0; i < seg && !hold_req; i++) begin
				case (style)
					0:       m_tready <= 1'b1;
					1:       m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// Result check against the oldest expectation
	always @(posedge clk) begin : result_check
		res_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = res_t'(m_tdata[5:0]);
			results++;
			cmd_seen[int'(got.pin_command)]++;
			woff_seen   += got.window_off;
			freset_seen += got.reset_req;
			if (pending_res.size() == 0) begin
				$error("result transfer with nothing expected: tdata %0h", m_tdata);
				fails++;
			end else begin
				want = pending_res.pop_front();
				if (got.pin_command !== want.pin_command) begin
					$error("pin_command: expected %0d, got %0d", want.pin_command,
						got.pin_command);
					fails++;
				end
				if (got.window_off !== want.window_off) begin
					$error("window_off: expected %0d, got %0d", want.window_off,
						got.window_off);
					fails++;
				end
				if (got.reset_req !== want.reset_req) begin
					$error("reset_req: expected %0d, got %0d", want.reset_req,
						got.reset_req);
					fails++;
				end
				if (got.pressed !== want.pressed) begin
					$error("pressed: expected %0d, got %0d", want.pressed, got.pressed);
					fails++;
				end
				if (got.busy_res !== want.busy_res) begin
					$error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
					fails++;
				end
			end
		end
	end

	// Watchdog on cycles with no transfer and no write
	always @(posedge clk) begin : stall_watch
		int idle;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle = 0;
		else
			idle++;
		if (idle >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Stimulus
	initial begin : stim
		int r, p;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_MOMENTARY_MODE;
		cfg_data  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed plan
		for (r = 0; r < PLAN_LEN; r++) begin
			if (plan_tab[r].kind == ROW_WRITE) begin
				wait_drained();
				write_reg(plan_tab[r].idx, plan_tab[r].val);
			end else begin
				send_tick(plan_tab[r].val[0], plan_tab[r].typed, plan_tab[r].want);
			end
		end

		// fastest settings
		set_mode(1'b1, 4'd2, 8'd1, 16'd1);
		press_mix(100);

		// slowest settings; receiver holds off while ticks keep coming
		set_mode(1'b0, 4'd15, 8'd255, 16'd65535);
		press_mix(20);
		hold_req = 1'b1;
		gapless  = 1'b1;
		press_mix(80);
		gapless  = 1'b0;

		// press count saturation, then let the window run out
		set_mode(1'b1, 4'd2, 8'd255, 16'd100);
		for (r = 0; r < 260; r++) begin
			send_tick(1'b1, 1'b0, NO_RES);
			send_tick(1'b0, 1'b0, NO_RES);
		end
		for (r = 0; r < 105; r++)
			send_tick(1'b0, 1'b0, NO_RES);

		// random settings, short windows and low limits mostly
		for (p = 0; p < 5; p++) begin
			set_mode(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
				8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
					: $urandom_range(0, 4)),
				16'(($urandom_range(0, 7) == 0) ? $urandom_range(1, 65535)
					: $urandom_range(0, 30)));
			press_mix(20);
			if (p == 2)
				wait_drained();
			press_mix(20);
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (pending_res.size() != 0) begin
			$error("%0d expected results never arrived", pending_res.size());
			fails++;
		end
		$display("Sent %0d ticks over %0d register writes, checked %0d results.",
			ticks_sent, writes, results);
		$display("Commands none/on/off/toggle %0d/%0d/%0d/%0d, window offs %0d, factory resets %0d.",
			cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], woff_seen, freset_seen);
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
